/* rtl/dcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCC transmitter package
// Command codes, register indexes, reset values and the frame bit lookup.
// ----------------------------------------------------------------------------
package dcc_pkg;

	localparam logic [1:0] CMD_SPEED = 2'd0;
	localparam logic [1:0] CMD_RAW   = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;
	localparam logic [1:0] CMD_FLUSH = 2'd3;

	localparam logic [1:0] REG_ONE_HALF  = 2'd0;
	localparam logic [1:0] REG_ZERO_HALF = 2'd1;
	localparam logic [1:0] REG_PREAMBLE  = 2'd2;

	localparam logic [7:0] ONE_HALF_RST  = 8'd58;
	localparam logic [7:0] ZERO_HALF_RST = 8'd100;
	localparam logic [4:0] PREAMBLE_RST  = 5'd14;

	localparam logic [6:0] ADDR_REJECT = 7'd127;
	localparam logic [5:0] SPEED_LIMIT = 6'd32;
	localparam logic [6:0] STOP_OFFSET = 7'd28;

	localparam int ENTRY_W = 13;
	localparam int FRAME_W = 24;

	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [FRAME_W-1:0] frame_t;

	// Bit at a frame position: preamble ones, then start bits and bytes msb first, then ones.
	function automatic logic frame_bit(input logic [5:0] pos, input logic [4:0] pre,
			input frame_t frame);
		logic [5:0] k;
		logic       b;
		k = pos - {1'b0, pre};
		if (pos < {1'b0, pre}) begin
			b = 1'b1;
		end else if (k inside {6'd0, 6'd9, 6'd18}) begin
			b = 1'b0;
		end else if (k >= 6'd27) begin
			b = 1'b1;
		end else if (k <= 6'd8) begin
			b = frame[5'(6'd24 - k)];
		end else if (k <= 6'd17) begin
			b = frame[5'(6'd25 - k)];
		end else begin
			b = frame[5'(6'd26 - k)];
		end
		return b;
	endfunction

	function automatic frame_t build_frame(input entry_t entry);
		logic [7:0] abyte;
		logic [7:0] dbyte;
		abyte = {1'b0, entry[12:6]};
		dbyte = {2'b01, entry[5:0]};
		return {abyte, dbyte, abyte ^ dbyte};
	endfunction

endpackage

/* rtl/dcc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCC generic RAM
// One write port, one read port with registered read data (old contents).
// ----------------------------------------------------------------------------
module dcc_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/dcc_packet_transmitter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCC packet transmitter
// Queues baseline packets and drives the complementary track waveform.
// ----------------------------------------------------------------------------
// One transaction per clock cycle in sustained operation while the sink does
// not stall: every command, including each microsecond tick, passes an input
// register and a result register before its result leaves. The packet
// queue sits in a RAM whose registered read port always points at the head,
// with a one-entry bypass for a write that lands on the head; this keeps
// dequeue in the same cycle as the tick that starts a packet.
module dcc_packet_transmitter_unit #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // address[6:0], direction[7], speed[13:8], data_bits[19:14], 0
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // accepted[0], line_a[1], line_b[2], busy_res[3], queue_count[7:4]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] HEAD_LAST = AW'(QUEUE_DEPTH - 1);
	localparam logic [FW:0]   DEPTH_X   = (FW + 1)'(QUEUE_DEPTH);

	logic               valid_s1;
	logic [1:0]         cmd_s1;
	logic [6:0]         addr_s1;
	logic               dir_s1;
	logic [5:0]         speed_s1;
	logic [5:0]         data_s1;

	logic               out_valid_q;
	logic [7:0]         out_data_q;

	logic [7:0]         one_half_q;
	logic [7:0]         zero_half_q;
	logic [4:0]         preamble_q;

	logic [AW-1:0]      head_q, head_d;
	logic [FW-1:0]      fill_q, fill_d;
	dcc_pkg::frame_t    frame_q, frame_d;
	logic [5:0]         pos_q, pos_d;
	logic [7:0]         half_cnt_q, half_cnt_d;
	logic               second_half_q, second_half_d;
	logic               sending_q, sending_d;
	logic               byp_q, byp_d;
	dcc_pkg::entry_t    byp_data_q;

	logic               out_ready;
	logic               proc;
	dcc_pkg::entry_t    ram_rdata;
	dcc_pkg::entry_t    head_entry;
	dcc_pkg::entry_t    wr_entry;
	logic               is_enq;
	logic               accept;
	logic [FW:0]        slot_sum;
	logic [AW-1:0]      slot;
	logic               start;
	dcc_pkg::frame_t    eff_frame;
	logic [5:0]         eff_pos;
	logic [7:0]         eff_half_cnt;
	logic               eff_second_half;
	logic [7:0]         half_len;
	logic [7:0]         half_inc;
	logic [5:0]         pos_inc;
	logic               line_a;
	logic [7:0]         result;

	assign out_ready = !out_valid_q || m_tready;
	assign proc      = valid_s1 && out_ready;
	assign s_tready  = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= s_tuser;
			addr_s1  <= s_tdata[6:0];
			dir_s1   <= s_tdata[7];
			speed_s1 <= s_tdata[13:8];
			data_s1  <= s_tdata[19:14];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_half_q  <= dcc_pkg::ONE_HALF_RST;
			zero_half_q <= dcc_pkg::ZERO_HALF_RST;
			preamble_q  <= dcc_pkg::PREAMBLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dcc_pkg::REG_ONE_HALF:  one_half_q  <= cfg_data;
				dcc_pkg::REG_ZERO_HALF: zero_half_q <= cfg_data;
				dcc_pkg::REG_PREAMBLE:  preamble_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign head_entry = byp_q ? byp_data_q : ram_rdata;
	assign wr_entry   = {addr_s1, (cmd_s1 == dcc_pkg::CMD_SPEED) ?
			{dir_s1, speed_s1[4:0]} : data_s1};
	assign is_enq     = (cmd_s1 == dcc_pkg::CMD_RAW) ||
			((cmd_s1 == dcc_pkg::CMD_SPEED) && (speed_s1 < dcc_pkg::SPEED_LIMIT));
	assign accept     = proc && is_enq && (addr_s1 != dcc_pkg::ADDR_REJECT) &&
			({1'b0, fill_q} < DEPTH_X);
	assign slot_sum   = {1'b0, (FW)'(head_q)} + {1'b0, fill_q};
	assign slot       = (slot_sum >= DEPTH_X) ? AW'(slot_sum - DEPTH_X) : AW'(slot_sum);
	assign start      = proc && (cmd_s1 == dcc_pkg::CMD_TICK) && !sending_q &&
			(fill_q != '0);

	assign eff_frame       = start ? dcc_pkg::build_frame(head_entry) : frame_q;
	assign eff_pos         = start ? 6'd0 : pos_q;
	assign eff_half_cnt    = start ? 8'd0 : half_cnt_q;
	assign eff_second_half = start ? 1'b0 : second_half_q;
	assign half_len        = dcc_pkg::frame_bit(eff_pos, preamble_q, eff_frame) ?
			one_half_q : zero_half_q;
	assign half_inc        = eff_half_cnt + 8'd1;
	assign pos_inc         = eff_pos + 6'd1;

	always_comb begin
		head_d        = head_q;
		fill_d        = fill_q;
		frame_d       = frame_q;
		pos_d         = pos_q;
		half_cnt_d    = half_cnt_q;
		second_half_d = second_half_q;
		sending_d     = sending_q;
		if (accept) begin
			fill_d = fill_q + FW'(1);
		end
		if (proc && (cmd_s1 == dcc_pkg::CMD_FLUSH)) begin
			fill_d = '0;
		end
		if (start) begin
			head_d    = (head_q == HEAD_LAST) ? '0 : head_q + AW'(1);
			fill_d    = fill_q - FW'(1);
			frame_d   = eff_frame;
			sending_d = 1'b1;
		end
		if (proc && (cmd_s1 == dcc_pkg::CMD_TICK) && (sending_q || start)) begin
			pos_d         = eff_pos;
			second_half_d = eff_second_half;
			if (half_inc < half_len) begin
				half_cnt_d = half_inc;
			end else begin
				half_cnt_d = 8'd0;
				if (!eff_second_half) begin
					second_half_d = 1'b1;
				end else begin
					second_half_d = 1'b0;
					pos_d         = pos_inc;
					if (({1'b0, pos_inc} >= {2'b00, preamble_q} + dcc_pkg::STOP_OFFSET) ||
							(pos_inc == 6'd0)) begin
						sending_d = 1'b0;
					end
				end
			end
		end
	end

	assign byp_d = accept && (slot == head_d);

	dcc_ram #(
		.WIDTH(dcc_pkg::ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk  (clk),
		.we   (accept),
		.waddr(slot),
		.wdata(wr_entry),
		.raddr(head_d),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			fill_q        <= '0;
			frame_q       <= '0;
			pos_q         <= '0;
			half_cnt_q    <= '0;
			second_half_q <= 1'b0;
			sending_q     <= 1'b0;
			byp_q         <= 1'b0;
		end else begin
			head_q        <= head_d;
			fill_q        <= fill_d;
			frame_q       <= frame_d;
			pos_q         <= pos_d;
			half_cnt_q    <= half_cnt_d;
			second_half_q <= second_half_d;
			sending_q     <= sending_d;
			byp_q         <= byp_d;
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= wr_entry;
	end

	assign line_a = sending_d && second_half_d;
	assign result = {4'(fill_d), sending_d, !line_a, line_a, accept};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, fill_q} <= DEPTH_X)
		else $error("queue fill beyond depth");

	a_accept_enq: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (cmd_s1 == dcc_pkg::CMD_SPEED || cmd_s1 == dcc_pkg::CMD_RAW))
		else $error("accept on a non-enqueue command");

	a_start_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sending_q) |-> $past(proc && cmd_s1 == dcc_pkg::CMD_TICK && fill_q != '0))
		else $error("packet started without a tick and a queued entry");

	a_line_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1]) |-> (m_tdata[3] && !m_tdata[2]))
		else $error("line A high while idle or lines not complementary");
`endif

endmodule

/* bench/dcc_packet_transmitter_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCC packet transmitter testbench
// Streams enqueue, flush and microsecond tick transactions into the
// transmitter. A predictor tracks the packet queue and the
// track waveform, and every result transaction is compared field by field.
// The run covers random source gaps and sink stalls and a range of bit
// timing and preamble setups.
// ----------------------------------------------------------------------------
module dcc_packet_transmitter_unit_tb;

	localparam int DEPTH       = 8;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [3:0] queue_count;
		logic       busy;
		logic       line_b;
		logic       line_a;
		logic       accepted;
	} track_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	dcc_pkg::entry_t pending_pkts[DEPTH];
	int              pkt_head;
	int              pkt_fill;
	dcc_pkg::frame_t tx_frame;
	logic [5:0]      tx_pos;
	logic [7:0]      tx_half_cnt;
	logic            tx_second;
	logic            tx_active;
	logic [7:0]      one_len;
	logic [7:0]      zero_len;
	logic [4:0]      preamble_len;

	track_result_t results_due[$];
	int            fail_count;
	bit            gaps_on;
	int            stall_left;
	int            cycle_count;

	dcc_packet_transmitter_unit #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic frame_level(input int pos);
		int k;
		int field_no;
		if (pos < preamble_len) return 1'b1;
		k = pos - preamble_len;
		if (k == 0 || k == 9 || k == 18) return 1'b0;
		if (k >= 27) return 1'b1;
		field_no = k / 9;
		return tx_frame[23 - field_no * 8 - (k - field_no * 9 - 1)];
	endfunction

	function automatic logic store_packet(input logic [6:0] addr, input logic [5:0] bits6);
		if (addr >= dcc_pkg::ADDR_REJECT || pkt_fill >= DEPTH) return 1'b0;
		pending_pkts[(pkt_head + pkt_fill) % DEPTH] = {addr, bits6};
		pkt_fill++;
		return 1'b1;
	endfunction

	function automatic void advance_tick();
		logic [7:0]      abyte;
		logic [7:0]      dbyte;
		logic [7:0]      span;
		dcc_pkg::entry_t head_entry;
		if (!tx_active) begin
			if (pkt_fill == 0) return;
			head_entry = pending_pkts[pkt_head];
			abyte = {1'b0, head_entry[12:6]};
			dbyte = {2'b01, head_entry[5:0]};
			tx_frame = {abyte, dbyte, abyte ^ dbyte};
			pkt_head = (pkt_head + 1) % DEPTH;
			pkt_fill--;
			tx_pos = '0;
			tx_half_cnt = '0;
			tx_second = 1'b0;
			tx_active = 1'b1;
		end
		span = frame_level(tx_pos) ? one_len : zero_len;
		tx_half_cnt = tx_half_cnt + 8'd1;
		if (tx_half_cnt < span) return;
		tx_half_cnt = '0;
		if (!tx_second) begin
			tx_second = 1'b1;
			return;
		end
		tx_second = 1'b0;
		tx_pos = tx_pos + 6'd1;
		if (tx_pos >= preamble_len + 28 || tx_pos == 6'd0) tx_active = 1'b0;
	endfunction

	function automatic track_result_t predict_track(input logic [1:0] cmd,
			input logic [6:0] addr, input logic dir, input logic [5:0] spd,
			input logic [5:0] bits6);
		track_result_t r;
		r = '0;
		case (cmd)
			dcc_pkg::CMD_SPEED: if (spd < dcc_pkg::SPEED_LIMIT)
				r.accepted = store_packet(addr, {dir, spd[4:0]});
			dcc_pkg::CMD_RAW:   r.accepted = store_packet(addr, bits6);
			dcc_pkg::CMD_TICK:  advance_tick();
			dcc_pkg::CMD_FLUSH: pkt_fill = 0;
			default: ;
		endcase
		r.line_a      = tx_active & tx_second;
		r.line_b      = ~r.line_a;
		r.busy        = tx_active;
		r.queue_count = 4'(pkt_fill);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [3:0] want,
			input logic [3:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic send_cmd(input logic [1:0] cmd, input logic [6:0] addr, input logic dir,
			input logic [5:0] spd, input logic [5:0] bits6);
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0, bits6, spd, dir, addr};
		results_due.push_back(predict_track(cmd, addr, dir, spd, bits6));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_tick();
		send_cmd(dcc_pkg::CMD_TICK, 7'($urandom), 1'($urandom), 6'($urandom), 6'($urandom));
	endtask

	task automatic send_random_cmd(input int enq_permille);
		int         pick;
		logic [1:0] cmd;
		logic [6:0] addr;
		logic [5:0] spd;
		pick = $urandom_range(0, 999);
		if (pick < enq_permille / 2) cmd = dcc_pkg::CMD_SPEED;
		else if (pick < enq_permille) cmd = dcc_pkg::CMD_RAW;
		else if (pick < enq_permille + 4) cmd = dcc_pkg::CMD_FLUSH;
		else cmd = dcc_pkg::CMD_TICK;
		addr = ($urandom_range(0, 15) == 0) ? dcc_pkg::ADDR_REJECT :
				7'($urandom_range(0, 127));
		spd = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 31));
		send_cmd(cmd, addr, 1'($urandom), spd, 6'($urandom));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_config(input logic [7:0] one, input logic [7:0] zero,
			input logic [4:0] pre);
		cfg_we    <= 1'b1;
		cfg_index <= dcc_pkg::REG_ONE_HALF;
		cfg_data  <= one;
		@(posedge clk);
		cfg_index <= dcc_pkg::REG_ZERO_HALF;
		cfg_data  <= zero;
		@(posedge clk);
		cfg_index <= dcc_pkg::REG_PREAMBLE;
		cfg_data  <= {3'($urandom), pre};
		@(posedge clk);
		cfg_we <= 1'b0;
		one_len      = one;
		zero_len     = zero;
		preamble_len = pre;
	endtask

	task automatic test_queue_limits();
		send_cmd(dcc_pkg::CMD_SPEED, 7'd0, 1'b0, 6'd0, 6'd0);
		send_cmd(dcc_pkg::CMD_SPEED, 7'd126, 1'b1, 6'd31, 6'd63);
		send_cmd(dcc_pkg::CMD_SPEED, 7'd5, 1'b0, dcc_pkg::SPEED_LIMIT, 6'd0);
		send_cmd(dcc_pkg::CMD_SPEED, dcc_pkg::ADDR_REJECT, 1'b1, 6'd63, 6'd63);
		send_cmd(dcc_pkg::CMD_RAW, dcc_pkg::ADDR_REJECT, 1'b0, 6'd0, 6'd63);
		send_cmd(dcc_pkg::CMD_RAW, 7'd85, 1'b1, 6'd63, 6'd63);
		send_cmd(dcc_pkg::CMD_RAW, 7'd42, 1'b0, 6'd0, 6'd0);
		send_cmd(dcc_pkg::CMD_TICK, 7'd127, 1'b1, 6'd63, 6'd63);
		send_cmd(dcc_pkg::CMD_FLUSH, 7'd127, 1'b1, 6'd63, 6'd63);
		send_cmd(dcc_pkg::CMD_TICK, 7'd0, 1'b0, 6'd0, 6'd0);
		for (int i = 0; i <= DEPTH; i++) begin
			send_cmd(dcc_pkg::CMD_RAW, 7'(i * 13), 1'b0, 6'd0, 6'(i * 7));
		end
		send_cmd(dcc_pkg::CMD_SPEED, 7'd1, 1'b0, 6'd1, 6'd0);
		send_cmd(dcc_pkg::CMD_FLUSH, 7'd0, 1'b0, 6'd0, 6'd0);
	endtask

	task automatic test_short_timing();
		wait_drained();
		apply_config(8'd0, 8'd0, 5'd0);
		send_cmd(dcc_pkg::CMD_SPEED, 7'd3, 1'b1, 6'd17, 6'd0);
		send_cmd(dcc_pkg::CMD_RAW, 7'd100, 1'b0, 6'd0, 6'd21);
		repeat (200) send_tick();
		wait_drained();
		apply_config(8'd1, 8'd0, 5'd9);
		send_cmd(dcc_pkg::CMD_RAW, 7'd64, 1'b0, 6'd0, 6'd42);
		repeat (160) send_tick();
	endtask

	task automatic test_preamble_change();
		wait_drained();
		apply_config(8'd1, 8'd2, 5'd31);
		send_cmd(dcc_pkg::CMD_RAW, 7'd0, 1'b0, 6'd0, 6'd0);
		repeat (100) send_tick();
		// shrink the preamble while the frame is already past the new stop bit
		wait_drained();
		apply_config(8'd1, 8'd2, 5'd10);
		repeat (20) send_tick();
		send_cmd(dcc_pkg::CMD_RAW, 7'd126, 1'b1, 6'd63, 6'd63);
		repeat (30) send_tick();
		wait_drained();
		apply_config(8'd1, 8'd2, 5'd20);
		repeat (200) send_tick();
	endtask

	task automatic test_random_traffic();
		logic [7:0] one;
		logic [7:0] zero;
		logic [4:0] pre;
		for (int p = 0; p < 9; p++) begin
			case (p)
				0: begin
					one = 8'd255; zero = 8'd255; pre = 5'd31;
				end
				1: begin
					one = 8'd1; zero = 8'd1; pre = 5'd10;
				end
				2: begin
					one = dcc_pkg::ONE_HALF_RST; zero = dcc_pkg::ZERO_HALF_RST;
					pre = dcc_pkg::PREAMBLE_RST;
				end
				default: begin
					one  = 8'($urandom_range(1, 3));
					zero = 8'($urandom_range(1, 4));
					pre  = 5'($urandom_range(10, 20));
				end
			endcase
			if (p == 8) gaps_on = 1'b0;
			wait_drained();
			apply_config(one, zero, pre);
			repeat (p < 3 ? 100 : 120) send_random_cmd((p % 2 == 1) ? 16 : 50);
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(0, 15);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		track_result_t got;
		track_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = track_result_t'(m_tdata);
			if (results_due.size() == 0) begin
				$error("result transaction with nothing expected: %h", m_tdata);
				fail_count++;
			end else begin
				want = results_due.pop_front();
				check_field("accepted", 4'(want.accepted), 4'(got.accepted));
				check_field("line_a", 4'(want.line_a), 4'(got.line_a));
				check_field("line_b", 4'(want.line_b), 4'(got.line_b));
				check_field("busy_res", 4'(want.busy), 4'(got.busy));
				check_field("queue_count", want.queue_count, got.queue_count);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL dcc_packet_transmitter_unit");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = dcc_pkg::CMD_SPEED;
		m_tready     = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = dcc_pkg::REG_ONE_HALF;
		cfg_data     = '0;
		fail_count   = 0;
		stall_left   = 0;
		cycle_count  = 0;
		gaps_on      = 1'b1;
		pkt_head     = 0;
		pkt_fill     = 0;
		tx_frame     = '0;
		tx_pos       = '0;
		tx_half_cnt  = '0;
		tx_second    = 1'b0;
		tx_active    = 1'b0;
		one_len      = dcc_pkg::ONE_HALF_RST;
		zero_len     = dcc_pkg::ZERO_HALF_RST;
		preamble_len = dcc_pkg::PREAMBLE_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_queue_limits();
		test_short_timing();
		test_preamble_change();
		test_random_traffic();
		wait_drained();
		if (fail_count == 0) begin
			$display("PASS dcc_packet_transmitter_unit");
		end else begin
			$display("FAIL dcc_packet_transmitter_unit");
		end
		$finish;
	end

endmodule
